// File: hw/rtl/cdls_pkg.sv
// Shared types, constants and digit helpers for the countdown LED matrix scanner.
package cdls_pkg;

    // Item kinds carried on the request tuser bit.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Default timebase settings.
    localparam int TICKS_PER_SECOND_DEF = 512;
    localparam int SHORT_DIVIDER_DEF    = 22;

    // Count limits and reset values.
    localparam logic [14:0] MAX_SECONDS_RESET = 15'd21599;
    localparam logic [14:0] LOAD_FALLBACK     = 15'd5;
    localparam logic [14:0] SECONDS_RESET     = 15'd5;

    // Matrix rows in scan order.
    localparam logic [2:0] ROW_SEC_LOW  = 3'd0;
    localparam logic [2:0] ROW_SEC_HIGH = 3'd1;
    localparam logic [2:0] ROW_SEC_TENS = 3'd2;
    localparam logic [2:0] ROW_MIN_LOW  = 3'd3;
    localparam logic [2:0] ROW_MIN_HIGH = 3'd4;
    localparam logic [2:0] ROW_MIN_TENS = 3'd5;
    localparam logic [2:0] ROW_HOURS    = 3'd6;
    localparam logic [2:0] ROW_LAST     = 3'd6;

    // Largest digit that still lights a column.
    localparam logic [3:0] COL_MAX = 4'd5;

    // Reciprocals for the constant divisions by 60 (exact over the used ranges).
    localparam logic [15:0] RECIP_60_SEC   = 16'd34953;  // s / 60 = (s * r) >> 21
    localparam int          SHIFT_60_SEC   = 21;
    localparam logic [10:0] RECIP_60_MIN   = 11'd1093;   // m / 60 = (m * r) >> 16
    localparam int          SHIFT_60_MIN   = 16;

    // Per-item data that travels down the display pipeline.
    typedef struct packed {
        logic [2:0]  row;
        logic [14:0] seconds;
        logic        short_tick;
        logic        second_elapsed;
        logic        dark;          // column forced off (blank or load)
    } t_item_meta;

    // Tens digit of a value 0..59: (v * 13) >> 7 is exact there.
    function automatic logic [3:0] tens_of_60(input logic [5:0] v);
        logic [9:0] prod;
        prod = {4'b0, v} * 10'd13;
        return {1'b0, prod[9:7]};
    endfunction

    // Units digit of a value 0..59.
    function automatic logic [3:0] units_of_60(input logic [5:0] v);
        logic [3:0] t;
        logic [5:0] t10;
        t   = tens_of_60(v);
        t10 = {t[2:0], 3'b0} + {2'b0, t[2:0], 1'b0};
        return 4'(v - t10);
    endfunction

    // Digit above five for the second row of a pair, else zero.
    function automatic logic [3:0] upper_digit(input logic [3:0] d);
        return (d >= 4'd6) ? 4'(d - 4'd5) : 4'd0;
    endfunction

endpackage

// File: hw/rtl/countdown_led_matrix_scanner_core.sv
// Countdown timer with divider, row scanner and column decoder for a 5x7 LED matrix.
//
// Usage:
// - Requests arrive on the s_axis channel. tuser selects the kind: a tick
//   (one scan step, TICKS_PER_SECOND per second) or a load of the seconds.
// - Every request gives exactly one result on the m_axis channel: the row
//   driven, its lit column, the seconds left, and the short-tick and
//   second-elapsed pulses.
// - max_seconds is written through i_cfg_wr_en / i_cfg_wr_data while idle.
// Timing:
// - A request passes through the input register and stages a, b and c to the output register.
// - Throughput is one request per cycle unless m_axis stalls; the timer state is
//   updated as a request leaves the input register, and the digit split (two reciprocal
//   multiplies for the divisions by 60) runs in a three-stage pipeline behind it.
// - Each stage holds its request while the next one is full and stalled, so
//   empty stages keep taking requests while the receiver stalls m_axis.
// Reset:
// - Seconds reload to five, the divider to TICKS_PER_SECOND, the scan row to
//   zero, max_seconds to 21599, and the pipeline empties.
module countdown_led_matrix_scanner_core
    import cdls_pkg::*;
#(
    parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF,
    parameter int SHORT_DIVIDER    = SHORT_DIVIDER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: max_seconds.
    input  logic        i_cfg_wr_en,
    input  logic [14:0] i_cfg_wr_data,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] load_seconds, [16] count_enable, [17] blank
    input  logic [0:0]  s_axis_tuser,   // [0] operation
    // Result channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [2:0] row_index, [5:3] column_select,
                                        // [20:6] seconds_left, [21] short_tick,
                                        // [22] second_elapsed
);

    localparam int DIV_W        = $clog2(TICKS_PER_SECOND + 1);
    localparam int SH_W         = $clog2(SHORT_DIVIDER + 1);
    localparam int SHORT_RELOAD = TICKS_PER_SECOND % SHORT_DIVIDER;

    // Configuration and timer state.
    logic [14:0]      r_max_seconds;
    logic [14:0]      r_seconds, n_seconds;
    logic [DIV_W-1:0] r_div, n_div;
    logic [SH_W-1:0]  r_short_rem, n_short_rem;
    logic [2:0]       r_scan_row, n_scan_row;

    // Input register.
    logic        r_in_v;
    logic        r_in_op;
    logic [15:0] r_in_load;
    logic        r_in_en;
    logic        r_in_blank;

    // Pipeline stages.
    logic        r_a_v, r_b_v, r_c_v, r_out_v;
    t_item_meta  r_a_meta, r_b_meta, r_c_meta, n_meta;
    logic [9:0]  r_b_min, r_c_min;
    logic [5:0]  r_c_sec;
    logic [3:0]  r_c_hr;
    logic [23:0] r_out_data;

    logic rdy_out, rdy_c, rdy_b, rdy_a;
    logic adv_in;

    // Each stage can take a request when empty or when it is moving on.
    assign rdy_out       = !r_out_v || m_axis_tready;
    assign rdy_c         = !r_c_v || rdy_out;
    assign rdy_b         = !r_b_v || rdy_c;
    assign rdy_a         = !r_a_v || rdy_b;
    assign s_axis_tready = !r_in_v || rdy_a;
    assign adv_in        = r_in_v && rdy_a;

    // Timer update for the request in the input register.
    always_comb begin
        n_seconds   = r_seconds;
        n_div       = r_div;
        n_short_rem = r_short_rem;
        n_scan_row  = r_scan_row;
        n_meta      = '{row: r_scan_row, seconds: r_seconds, short_tick: 1'b0,
                        second_elapsed: 1'b0, dark: 1'b1};
        if (r_in_op == OP_LOAD) begin
            n_seconds = ({1'b0, r_max_seconds} < r_in_load) ? LOAD_FALLBACK
                                                             : r_in_load[14:0];
        end else begin
            n_meta.short_tick = (r_short_rem == '0);
            if (r_div <= DIV_W'(1)) begin
                n_div                 = DIV_W'(TICKS_PER_SECOND);
                n_short_rem           = SH_W'(SHORT_RELOAD);
                n_meta.second_elapsed = 1'b1;
                if (r_in_en && (r_seconds != '0)) begin
                    n_seconds = r_seconds - 15'd1;
                end
            end else begin
                n_div       = r_div - DIV_W'(1);
                n_short_rem = (r_short_rem == '0) ? SH_W'(SHORT_DIVIDER - 1)
                                                  : r_short_rem - SH_W'(1);
            end
            n_scan_row  = (r_scan_row >= ROW_LAST) ? ROW_SEC_LOW : r_scan_row + 3'd1;
            n_meta.dark = r_in_blank;
        end
        n_meta.seconds = n_seconds;
    end

    // Control state: configuration, timer and stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_seconds <= MAX_SECONDS_RESET;
            r_seconds     <= SECONDS_RESET;
            r_div         <= DIV_W'(TICKS_PER_SECOND);
            r_short_rem   <= SH_W'(SHORT_RELOAD);
            r_scan_row    <= ROW_SEC_LOW;
            r_in_v        <= 1'b0;
            r_a_v         <= 1'b0;
            r_b_v         <= 1'b0;
            r_c_v         <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_seconds <= i_cfg_wr_data;
            end
            if (adv_in) begin
                r_seconds   <= n_seconds;
                r_div       <= n_div;
                r_short_rem <= n_short_rem;
                r_scan_row  <= n_scan_row;
            end
            if (s_axis_tready) r_in_v  <= s_axis_tvalid;
            if (rdy_a)         r_a_v   <= r_in_v;
            if (rdy_b)         r_b_v   <= r_a_v;
            if (rdy_c)         r_c_v   <= r_b_v;
            if (rdy_out)       r_out_v <= r_c_v;
        end
    end

    // Digit split: minutes, then seconds-in-minute and hours, then minutes-in-hour.
    logic [30:0] min_prod;
    logic [20:0] hr_prod;
    logic [15:0] min_x60;
    logic [9:0]  hr_x60;
    logic [5:0]  mm;
    logic [5:0]  digit_src;
    logic [3:0]  digit_units, digit_tens, digit;
    logic [2:0]  col;

    assign min_prod = 31'(r_a_meta.seconds) * 31'(RECIP_60_SEC);
    assign min_x60  = {r_b_min, 6'b0} - {4'b0, r_b_min, 2'b0};
    assign hr_prod  = 21'(r_b_min) * 21'(RECIP_60_MIN);
    assign hr_x60   = {r_c_hr, 6'b0} - {4'b0, r_c_hr, 2'b0};
    assign mm       = 6'(r_c_min - hr_x60);

    // Column for the row: pick the digit, then blank dark items and values above five.
    assign digit_src   = (r_c_meta.row < ROW_MIN_LOW) ? r_c_sec : mm;
    assign digit_units = units_of_60(digit_src);
    assign digit_tens  = tens_of_60(digit_src);

    always_comb begin
        case (r_c_meta.row)
            ROW_SEC_LOW,  ROW_MIN_LOW:  digit = digit_units;
            ROW_SEC_HIGH, ROW_MIN_HIGH: digit = upper_digit(digit_units);
            ROW_SEC_TENS, ROW_MIN_TENS: digit = digit_tens;
            default:                    digit = r_c_hr;
        endcase
    end

    assign col = (r_c_meta.dark || (digit > COL_MAX)) ? 3'd0 : digit[2:0];

    // Payload registers, loaded when their stage advances.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_op    <= s_axis_tuser[0];
            r_in_load  <= s_axis_tdata[15:0];
            r_in_en    <= s_axis_tdata[16];
            r_in_blank <= s_axis_tdata[17];
        end
        if (rdy_a) begin
            r_a_meta <= n_meta;
        end
        if (rdy_b) begin
            r_b_meta <= r_a_meta;
            r_b_min  <= min_prod[SHIFT_60_SEC +: 10];
        end
        if (rdy_c) begin
            r_c_meta <= r_b_meta;
            r_c_min  <= r_b_min;
            r_c_sec  <= 6'(r_b_meta.seconds - min_x60[14:0]);
            r_c_hr   <= hr_prod[SHIFT_60_MIN +: 4];
        end
        if (rdy_out) begin
            r_out_data <= {1'b0, r_c_meta.second_elapsed, r_c_meta.short_tick,
                           r_c_meta.seconds, col, r_c_meta.row};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // The scan row only ever walks the seven rows.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_row <= ROW_LAST)
        else $error("scan row out of range");

    // The divider stays between one and a full second.
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div >= DIV_W'(1)) && (r_div <= DIV_W'(TICKS_PER_SECOND)))
        else $error("tick divider out of range");

    // A reload of the divider restarts the short-tick phase.
    a_short_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv_in && (r_in_op == OP_TICK) && (r_div <= DIV_W'(1)))
        |=> (r_short_rem == SH_W'(SHORT_RELOAD)))
        else $error("short tick phase lost on divider reload");
`endif

endmodule
